// ===== src/cllst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cllst_pkg: shared types and constants
// Codes, field widths and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package cllst_pkg;

  localparam int KEY_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int FIELD_W     = 5;   // entry_count and head_slot
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;  // 12 bits of fields padded to 2 bytes
  localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - 2 * FIELD_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;      // capture input word
    logic    scan_clr;  // restart key scan
    logic    scan_step; // issue next key read, compare previous
    logic    rd_hit;    // read links of matched slot
    logic    unlink;    // detach matched slot
    logic    rd_last;   // read key and links of last slot
    logic    fill;      // copy last slot into the hole
    logic    relink;    // point neighbors of moved slot at the hole
    logic    shrink;    // drop the last slot
    logic    ins_slot;  // write new slot
    logic    ins_link;  // link old head back, bump count
    logic    out_load;  // load result register
    status_t res_code;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic hit;
    logic miss_end;
    logic hit_is_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== src/compact_linked_list_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_linked_list_store_core: compact doubly linked list of 32-bit keys
//
// Input words (s_*) carry a command in s_tuser (0 insert, 1 remove) and a
// key in s_tdata. Each input word yields exactly one result word on m_*:
// status, entry count and head slot after the operation.
// Entries live in slots 0..count-1 of key/next/prev memories; a remove
// fills the hole with the last slot so storage stays dense.
// Insert: writes the new slot, then links the old head back and bumps the count.
// Remove: the key memory is scanned one slot per cycle through its single
// registered read port, then a short link read-modify-write sequence runs;
// the scan stops at the first matching slot.
// Errors (overflow, underflow, not found) finish early with no state change.
// One word is worked on at a time; s_tready is high only while idle.
// The result register lets the next input word in while a result waits;
// a stalled m_tready holds the sequencer at its final step until the
// previous result is taken.
// Reset: list empty (count 0, head = CAPACITY), no result pending.
// Memory contents are not cleared; only slots below count are ever read.
// ----------------------------------------------------------------------------
module compact_linked_list_store_core #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [cllst_pkg::IN_TDATA_W-1:0]  s_tdata,   // [31:0] key_value
  input  logic                              s_tuser,   // [0] command
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cllst_pkg::OUT_TDATA_W-1:0] m_tdata    // [1:0] status,
                                                       // [6:2] entry_count,
                                                       // [11:7] head_slot,
                                                       // [15:12] zero
);
  import cllst_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  // sequencer: one step of an operation per state
  cllst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .ctl      (ctl),
    .sts      (sts)
  );

  // storage, scan compare and result register
  cllst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== src/cllst_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cllst_datapath: list storage and result register
// Key and link memories, head and count registers, scan compare, output word.
// ----------------------------------------------------------------------------
module cllst_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cllst_pkg::dp_ctl_t                   ctl,
  output cllst_pkg::dp_sts_t                   sts,
  input  logic [cllst_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [cllst_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import cllst_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] NIL = CNT_W'(CAPACITY);

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [CNT_W-1:0] next_mem [CAPACITY];
  logic [CNT_W-1:0] prev_mem [CAPACITY];

  logic             cmd_q;
  logic [KEY_W-1:0] key_in;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] head, head_next;
  logic [CNT_W-1:0] scan_ptr;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] next_q, prev_q;

  logic [STATUS_W-1:0] out_status;
  logic [FIELD_W-1:0]  out_count, out_head;

  logic [CNT_W-1:0] last;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W-1:0] hit_link;
  logic             scan_issue;
  logic             hit;

  logic             key_we, nx_we, pv_we;
  logic [IDX_W-1:0] key_wa, nx_wa, pv_wa;
  logic [KEY_W-1:0] key_wd;
  logic [CNT_W-1:0] nx_wd, pv_wd;
  logic             key_re, lk_re;
  logic [IDX_W-1:0] key_ra, lk_ra;

  assign last       = count - CNT_W'(1);
  assign last_idx   = last[IDX_W-1:0];
  assign hit_link   = CNT_W'(cmp_idx);
  assign scan_issue = ctl.scan_step && (scan_ptr <= last);
  assign hit        = cmp_valid && (key_q == key_in);

  assign sts.is_remove   = (cmd_q == CMD_REMOVE);
  assign sts.full        = (count >= NIL);
  assign sts.empty       = (count == '0);
  assign sts.hit         = hit;
  assign sts.miss_end    = cmp_valid && !hit && (cmp_idx == last_idx);
  assign sts.hit_is_last = (cmp_idx == last_idx);
  assign sts.out_free    = !m_tvalid || m_tready;

  always_comb begin
    key_we     = 1'b0;
    key_wa     = '0;
    key_wd     = '0;
    nx_we      = 1'b0;
    nx_wa      = '0;
    nx_wd      = '0;
    pv_we      = 1'b0;
    pv_wa      = '0;
    pv_wd      = '0;
    key_re     = scan_issue;
    key_ra     = scan_ptr[IDX_W-1:0];
    lk_re      = 1'b0;
    lk_ra      = cmp_idx;
    count_next = count;
    head_next  = head;

    if (ctl.rd_hit) begin
      lk_re = 1'b1;
    end

    if (ctl.rd_last) begin
      key_re = 1'b1;
      key_ra = last_idx;
      lk_re  = 1'b1;
      lk_ra  = last_idx;
    end

    if (ctl.ins_slot) begin
      key_we = 1'b1;
      key_wa = count[IDX_W-1:0];
      key_wd = key_in;
      nx_we  = 1'b1;
      nx_wa  = count[IDX_W-1:0];
      nx_wd  = head;
      pv_we  = 1'b1;
      pv_wa  = count[IDX_W-1:0];
      pv_wd  = NIL;
    end

    if (ctl.ins_link) begin
      if (head < NIL) begin
        pv_we = 1'b1;
        pv_wa = head[IDX_W-1:0];
        pv_wd = count;
      end
      head_next  = count;
      count_next = count + CNT_W'(1);
    end

    // links of the matched slot sit in prev_q / next_q
    if (ctl.unlink) begin
      if (prev_q < NIL) begin
        nx_we = 1'b1;
        nx_wa = prev_q[IDX_W-1:0];
        nx_wd = next_q;
      end else begin
        head_next = (next_q < NIL) ? next_q : NIL;
      end
      if (next_q < NIL) begin
        pv_we = 1'b1;
        pv_wa = next_q[IDX_W-1:0];
        pv_wd = prev_q;
      end
    end

    // key_q / links now hold the last slot
    if (ctl.fill) begin
      key_we = 1'b1;
      key_wa = cmp_idx;
      key_wd = key_q;
      nx_we  = 1'b1;
      nx_wa  = cmp_idx;
      nx_wd  = next_q;
      pv_we  = 1'b1;
      pv_wa  = cmp_idx;
      pv_wd  = prev_q;
    end

    if (ctl.relink) begin
      if (prev_q < NIL) begin
        nx_we = 1'b1;
        nx_wa = prev_q[IDX_W-1:0];
        nx_wd = hit_link;
      end else begin
        head_next = hit_link;
      end
      if (next_q < NIL) begin
        pv_we = 1'b1;
        pv_wa = next_q[IDX_W-1:0];
        pv_wd = hit_link;
      end
    end

    if (ctl.shrink) begin
      count_next = last;
      if (last == '0) begin
        head_next = NIL;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    if (key_re) begin
      key_q <= key_mem[key_ra];
    end
    if (lk_re) begin
      next_q <= next_mem[lk_ra];
      prev_q <= prev_mem[lk_ra];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= s_tuser;
      key_in <= s_tdata;
    end
    if (ctl.scan_clr) begin
      scan_ptr <= '0;
    end else if (scan_issue) begin
      scan_ptr <= scan_ptr + CNT_W'(1);
    end
    if (scan_issue) begin
      cmp_idx <= scan_ptr[IDX_W-1:0];
    end
    if (ctl.out_load) begin
      out_status <= ctl.res_code;
      out_count  <= FIELD_W'(count);
      out_head   <= FIELD_W'(head);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      head      <= NIL;
      cmp_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      count <= count_next;
      head  <= head_next;
      if (ctl.scan_clr) begin
        cmp_valid <= 1'b0;
      end else if (ctl.scan_step) begin
        cmp_valid <= scan_issue;
      end
      if (ctl.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_head, out_count, out_status};

endmodule

// ===== src/cllst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cllst_ctrl: operation sequencer
// One-hot state machine stepping insert and remove through the datapath.
// ----------------------------------------------------------------------------
module cllst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output cllst_pkg::dp_ctl_t ctl,
  input  cllst_pkg::dp_sts_t sts
);
  import cllst_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISPATCH = 12'b0000_0000_0010,
    S_SCAN     = 12'b0000_0000_0100,
    S_RD_HIT   = 12'b0000_0000_1000,
    S_UNLINK   = 12'b0000_0001_0000,
    S_RD_LAST  = 12'b0000_0010_0000,
    S_FILL     = 12'b0000_0100_0000,
    S_RELINK   = 12'b0000_1000_0000,
    S_SHRINK   = 12'b0001_0000_0000,
    S_INS_SLOT = 12'b0010_0000_0000,
    S_INS_LINK = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_t;

  state_t  state, state_next;
  status_t res_code, res_code_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    ctl           = '0;
    ctl.res_code  = res_code;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_code_next = ST_OK;
        if (!sts.is_remove) begin
          if (sts.full) begin
            res_code_next = ST_OVERFLOW;
            state_next    = S_RESP;
          end else begin
            state_next = S_INS_SLOT;
          end
        end else if (sts.empty) begin
          res_code_next = ST_UNDERFLOW;
          state_next    = S_RESP;
        end else begin
          ctl.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_next = S_RD_HIT;
        end else if (sts.miss_end) begin
          res_code_next = ST_NOTFOUND;
          state_next    = S_RESP;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_RD_HIT: begin
        ctl.rd_hit = 1'b1;
        state_next = S_UNLINK;
      end
      S_UNLINK: begin
        ctl.unlink = 1'b1;
        state_next = sts.hit_is_last ? S_SHRINK : S_RD_LAST;
      end
      S_RD_LAST: begin
        ctl.rd_last = 1'b1;
        state_next  = S_FILL;
      end
      S_FILL: begin
        ctl.fill   = 1'b1;
        state_next = S_RELINK;
      end
      S_RELINK: begin
        ctl.relink = 1'b1;
        state_next = S_SHRINK;
      end
      S_SHRINK: begin
        ctl.shrink = 1'b1;
        state_next = S_RESP;
      end
      S_INS_SLOT: begin
        ctl.ins_slot = 1'b1;
        state_next   = S_INS_LINK;
      end
      S_INS_LINK: begin
        ctl.ins_link = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_code <= ST_OK;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

endmodule

// ===== tb/tb_compact_linked_list_store_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compact_linked_list_store_core: self-checking bench for the list store
// Drives insert/remove words on the input stream and keeps its own copy of
// the dense linked list. Each result word is checked field by field against
// the oldest predicted status, entry count and head slot.
// Directed runs cover extreme keys, underflow, overflow, not found, head
// removal and relocation of the head slot. An output stall test and a long
// random run follow, with random idling on both sides and drained pauses.
// ----------------------------------------------------------------------------
module tb_compact_linked_list_store_core;
  import cllst_pkg::*;

  localparam int         LIST_CAP   = 16;
  localparam logic [4:0] LINK_NULL  = 5'd16;
  localparam int         MAX_IDLE   = 12;
  localparam int         TAIL_WAIT  = 40;   // longer than a full-scan remove
  localparam int         SINK_HOLD  = 300;  // long output stall, in cycles
  localparam int         RAND_PHASE = 50;
  localparam int         RAND_COUNT = 38;

  typedef struct {
    status_t    status;
    logic [4:0] count;
    logic [4:0] head;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [31:0] key_value
  logic                   s_tuser;   // [0] command
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [1:0] status, [6:2] entry_count,
                                     // [11:7] head_slot, [15:12] zero

  // shadow copy of the list
  logic [31:0] list_keys [LIST_CAP];
  logic [4:0]  list_next [LIST_CAP];
  logic [4:0]  list_prev [LIST_CAP];
  logic [4:0]  list_head;
  logic [4:0]  list_count;

  list_result_t awaited_results[$];
  int           mismatch_count = 0;
  int           src_max_idle = 0;
  int           sink_max_idle = 0;
  int           sink_hold_req = 0;

  always #2 clk = ~clk;

  compact_linked_list_store_core #(.CAPACITY(LIST_CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Apply one command to the shadow list, return the result it must produce.
  function automatic list_result_t list_apply(cmd_t cmd, logic [31:0] key);
    list_result_t r;
    int           hit;
    int           last;
    int           i;
    logic [4:0]   p;
    logic [4:0]   n;
    r.status = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (list_count >= LIST_CAP) begin
        r.status = ST_OVERFLOW;
      end else begin
        list_keys[list_count] = key;
        list_prev[list_count] = LINK_NULL;
        list_next[list_count] = list_head;
        if (list_head < LIST_CAP) list_prev[list_head] = list_count;
        list_head  = list_count;
        list_count = list_count + 5'd1;
      end
    end else if (list_count == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      last = list_count - 1;
      hit  = -1;
      for (i = 0; i <= last && hit < 0; i++)
        if (list_keys[i] == key) hit = i;
      if (hit < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        // detach the matched slot
        p = list_prev[hit];
        n = list_next[hit];
        if (p < LIST_CAP) list_next[p] = n;
        else list_head = (n < LIST_CAP) ? n : LINK_NULL;
        if (n < LIST_CAP) list_prev[n] = p;
        // move the last slot into the hole, head follows it if needed
        if (hit < last) begin
          list_keys[hit] = list_keys[last];
          list_next[hit] = list_next[last];
          list_prev[hit] = list_prev[last];
          p = list_prev[last];
          n = list_next[last];
          if (p < LIST_CAP) list_next[p] = 5'(hit);
          else list_head = 5'(hit);
          if (n < LIST_CAP) list_prev[n] = 5'(hit);
        end
        list_count = 5'(last);
        if (list_count == 0) list_head = LINK_NULL;
      end
    end
    r.count = list_count;
    r.head  = list_head;
    return r;
  endfunction

  // Send one word; called and returns at a falling edge.
  task automatic send_word(input cmd_t cmd, input logic [31:0] key);
    int gap;
    gap = (src_max_idle == 0) ? 0 : $urandom_range(src_max_idle, 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= key;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    awaited_results.push_back(list_apply(cmd, key));
    @(negedge clk);
  endtask

  // Sender goes quiet until every result has come back.
  task automatic drain_results;
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Remove on an empty list.
  task automatic test_empty_remove;
    send_word(CMD_REMOVE, 32'h0000_0000);
  endtask

  // Extreme keys, a miss, removal of the head and relocation of the head slot.
  task automatic test_extreme_keys;
    send_word(CMD_INSERT, 32'h8000_0000);
    send_word(CMD_INSERT, 32'h7FFF_FFFF);
    send_word(CMD_INSERT, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 32'h0000_0000);
    send_word(CMD_REMOVE, 32'h1234_5678);  // miss
    send_word(CMD_REMOVE, 32'h7FFF_FFFF);  // last slot (head) moves into slot 1
    send_word(CMD_REMOVE, 32'h0000_0000);  // removes the head entry
  endtask

  // Fill with duplicate keys, overflow, then remove the first stored copy of key 1.
  task automatic test_fill_overflow;
    int k;
    k = 0;
    while (list_count < LIST_CAP) begin
      send_word(CMD_INSERT, 32'(k % 3));
      k++;
    end
    send_word(CMD_INSERT, 32'hDEAD_BEEF);
    send_word(CMD_REMOVE, 32'h0000_0001);
  endtask

  // Output held off for a long time while input keeps coming.
  task automatic test_output_stall;
    int k;
    drain_results();
    src_max_idle  = 0;
    sink_max_idle = 0;
    sink_hold_req = SINK_HOLD;
    for (k = 0; k < 12; k++)
      send_word((k % 3 == 2) ? CMD_REMOVE : CMD_INSERT, $urandom);
    drain_results();
  endtask

  // Mostly well-formed traffic: removes usually target keys that are stored.
  task automatic test_random_traffic;
    logic [31:0] key_pool [8];
    int          ph;
    int          k;
    int          j;
    int          ins_pct;
    int          sel;
    logic [31:0] key;
    cmd_t        cmd;
    for (ph = 0; ph < RAND_COUNT; ph++) begin
      if (ph % 4 == 3) drain_results();
      case ($urandom_range(2, 0))
        0:       src_max_idle = 0;
        1:       src_max_idle = MAX_IDLE;
        default: src_max_idle = $urandom_range(MAX_IDLE, 1);
      endcase
      case ($urandom_range(2, 0))
        0:       sink_max_idle = 0;
        1:       sink_max_idle = MAX_IDLE;
        default: sink_max_idle = $urandom_range(MAX_IDLE, 1);
      endcase
      case (ph % 3)
        0:       ins_pct = 80;
        1:       ins_pct = 50;
        default: ins_pct = 20;
      endcase
      for (j = 0; j < 8; j++) key_pool[j] = $urandom;
      for (k = 0; k < RAND_PHASE; k++) begin
        sel = $urandom_range(99, 0);
        cmd = ($urandom_range(99, 0) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
        if (cmd == CMD_INSERT)
          key = (sel < 70) ? key_pool[$urandom_range(7, 0)] : $urandom;
        else if (sel < 70 && list_count != 0)
          key = list_keys[$urandom_range(list_count - 1, 0)];
        else if (sel < 90)
          key = key_pool[$urandom_range(7, 0)];
        else
          key = $urandom;
        send_word(cmd, key);
      end
    end
  endtask

  // Result checker.
  initial begin
    list_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with none expected, got %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata[1:0] != want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, m_tdata[1:0]);
            mismatch_count++;
          end
          if (m_tdata[6:2] != want.count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want.count,
                     m_tdata[6:2]);
            mismatch_count++;
          end
          if (m_tdata[11:7] != want.head) begin
            $display("%0t: head_slot expected %0d got %0d", $time, want.head,
                     m_tdata[11:7]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Result sink: random stall per word, or a long requested hold-off.
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (sink_hold_req != 0) begin
        stall = sink_hold_req;
        sink_hold_req = 0;
      end else begin
        stall = (sink_max_idle == 0) ? 0 : $urandom_range(sink_max_idle, 0);
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("[compact_linked_list_store_core] ERROR");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = CMD_INSERT;
    s_tdata   = '0;
    list_head  = LINK_NULL;
    list_count = 5'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_remove();
    test_extreme_keys();
    test_fill_overflow();
    test_output_stall();
    test_random_traffic();

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("[compact_linked_list_store_core] OK");
    else
      $display("[compact_linked_list_store_core] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cllst_pkg.sv
src/cllst_datapath.sv
src/cllst_ctrl.sv
src/compact_linked_list_store_core.sv
tb/tb_compact_linked_list_store_core.sv
